// ----- hw/rtl/periodic_event_step_limiter_top_macros.svh -----
// Assertion macros shared by the checker of the step limiter.
`ifndef PERIODIC_EVENT_STEP_LIMITER_TOP_MACROS_SVH
`define PERIODIC_EVENT_STEP_LIMITER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PESL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PESL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pesl_pkg.sv -----
package pesl_pkg;

	localparam int MAX_EVENTS_DEF = 16;
	localparam int TIME_BITS_DEF  = 48;

	// Field widths on the ports.
	localparam int FIELD_TIME_W = 48;
	localparam int EVENT_ID_W   = 4;
	localparam int REQ_W        = 2;

	// Input word layout, lowest bit first.
	localparam int ID_LSB    = 0;
	localparam int IV_LSB    = ID_LSB + EVENT_ID_W;
	localparam int PREV_LSB  = IV_LSB + FIELD_TIME_W;
	localparam int TIME_LSB  = PREV_LSB + FIELD_TIME_W;
	localparam int S_USED_W  = TIME_LSB + FIELD_TIME_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

	// Output word layout: next_interval, then found.
	localparam int M_USED_W  = FIELD_TIME_W + 1;
	localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_END  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_SCHEDULE = 2'd0,
		REQ_CANCEL   = 2'd1,
		REQ_RESET    = 2'd2,
		REQ_QUERY    = 2'd3
	} req_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	// Per-slot flags looked up for the entry whose read data just arrived.
	typedef struct packed {
		logic slot_valid;
		logic lm_zero;
	} slot_flags_t;

	// Status of the slot pipeline seen by the controller.
	typedef struct packed {
		logic busy;
		logic wb_en;
		logic upd_en;
	} pipe_stat_t;

endpackage

// ----- hw/rtl/periodic_event_step_limiter_top.sv -----
// Schedule, cancel and timer reset words go from idle through the result state to the output register.
// Query: the word passes through prep, a walk that reads one timer slot per cycle from the
// slot memory, a drain of the slot pipeline and the result state; a query at or after the
// run end goes from prep straight to the result state. One word is in work at a time; the
// next is taken the cycle after the result has moved into the output register.
// Reset clears slot validity, the configuration registers and the output valid; no clearing pass is run.
module periodic_event_step_limiter_top import pesl_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// event_id, interval, prev_meas, current_time, zero fill
	input  logic [S_TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [REQ_W-1:0]        s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// next_interval, found, zero fill
	output logic [M_TDATA_W-1:0]    m_axis_tdata,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [FIELD_TIME_W-1:0] cfg_data
);

	localparam int TW     = TIME_BITS;
	localparam int SLOT_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CNT_W  = $clog2(MAX_EVENTS + 1);

	state_t state_q, state_d;

	logic [TW-1:0]         run_end_q, max_step_q;
	logic [TW-1:0]         t_q, end_q, res_q;
	logic                  found_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic [MAX_EVENTS-1:0] slot_vld_q, lm_zero_q;

	logic                    m_valid_q, out_found_q;
	logic [FIELD_TIME_W-1:0] out_step_q;

	logic              accept, in_range, out_free, issue, past_end;
	req_t              req;
	logic [SLOT_W-1:0] sid, idx_s1, wb_idx;
	logic [TW-1:0]     iv_in, prev_in, time_in;
	logic [TW:0]       tsum;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [2*TW-1:0]   mem_wdata, mem_rdata;
	logic [TW-1:0]     wb_iv, wb_lm, nxt_s3;
	slot_flags_t       flags;
	pipe_stat_t        stat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req           = req_t'(s_axis_tuser);
	assign sid           = SLOT_W'(s_axis_tdata[ID_LSB +: EVENT_ID_W]);
	assign in_range      = 32'(s_axis_tdata[ID_LSB +: EVENT_ID_W]) < 32'(MAX_EVENTS);
	assign iv_in         = TW'(s_axis_tdata[IV_LSB +: FIELD_TIME_W]);
	assign prev_in       = TW'(s_axis_tdata[PREV_LSB +: FIELD_TIME_W]);
	assign time_in       = TW'(s_axis_tdata[TIME_LSB +: FIELD_TIME_W]);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign issue         = (state_q == ST_WALK);
	assign past_end      = t_q >= run_end_q;
	assign tsum          = {1'b0, t_q} + {1'b0, max_step_q};
	assign cfg_ready     = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (req == REQ_QUERY) ? ST_PREP : ST_RESULT;
				end
			end
			ST_PREP: begin
				state_d = past_end ? ST_RESULT : ST_WALK;
			end
			ST_WALK: begin
				if (rd_cnt_q == CNT_W'(MAX_EVENTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_end_q  <= '0;
			max_step_q <= '0;
			slot_vld_q <= '0;
			lm_zero_q  <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RUN_END:  run_end_q  <= TW'(cfg_data);
					REG_MAX_STEP: max_step_q <= TW'(cfg_data);
					default: ;
				endcase
			end
			if (accept && in_range && req == REQ_SCHEDULE) begin
				slot_vld_q[sid] <= 1'b1;
				lm_zero_q[sid]  <= 1'b0;
			end else if (accept && in_range && req == REQ_CANCEL) begin
				slot_vld_q[sid] <= 1'b0;
			end else if (accept && req == REQ_RESET) begin
				// A set flag makes the slot read as last measured at time zero.
				lm_zero_q <= '1;
			end else if (stat.wb_en) begin
				lm_zero_q[wb_idx] <= 1'b0;
			end
			if (state_q == ST_RESULT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q     <= time_in;
			res_q   <= '0;
			found_q <= (req == REQ_CANCEL) && in_range && slot_vld_q[sid];
		end
		if (state_q == ST_PREP) begin
			rd_cnt_q <= '0;
			// The end of the step is tracked as an absolute time.
			end_q    <= (tsum >= {1'b0, run_end_q}) ? run_end_q : tsum[TW-1:0];
		end else if (issue) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
		if (stat.upd_en && end_q >= nxt_s3) begin
			end_q <= (nxt_s3 > t_q) ? nxt_s3 : t_q;
		end
		if (state_q == ST_DRAIN && !stat.busy) begin
			res_q <= end_q - t_q;
		end
		if (state_q == ST_RESULT && out_free) begin
			out_step_q  <= FIELD_TIME_W'(res_q);
			out_found_q <= found_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_found_q, out_step_q};

	// Schedule writes and walk write-backs never fall in the same cycle.
	assign mem_we    = (accept && in_range && req == REQ_SCHEDULE) || stat.wb_en;
	assign mem_waddr = stat.wb_en ? wb_idx : sid;
	assign mem_wdata = stat.wb_en ? {wb_iv, wb_lm} : {iv_in, prev_in};

	assign flags.slot_valid = slot_vld_q[idx_s1];
	assign flags.lm_zero    = lm_zero_q[idx_s1];

	pesl_slot_mem #(
		.DEPTH (MAX_EVENTS),
		.AW    (SLOT_W),
		.DW    (2 * TW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rd_cnt_q[SLOT_W-1:0]),
		.rdata (mem_rdata)
	);

	pesl_slot_pipe #(
		.TW     (TW),
		.SLOT_W (SLOT_W)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.issue_idx (rd_cnt_q[SLOT_W-1:0]),
		.rd_iv     (mem_rdata[2*TW-1:TW]),
		.rd_lm     (mem_rdata[TW-1:0]),
		.flags     (flags),
		.cur_time  (t_q),
		.idx_s1    (idx_s1),
		.stat      (stat),
		.wb_idx    (wb_idx),
		.wb_iv     (wb_iv),
		.wb_lm     (wb_lm),
		.nxt_s3    (nxt_s3)
	);

endmodule

// ----- hw/rtl/pesl_slot_mem.sv -----
module pesl_slot_mem import pesl_pkg::*; #(
	parameter int DEPTH = MAX_EVENTS_DEF,
	parameter int AW    = 4,
	parameter int DW    = 2 * TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/pesl_slot_pipe.sv -----
module pesl_slot_pipe import pesl_pkg::*; #(
	parameter int TW     = TIME_BITS_DEF,
	parameter int SLOT_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  logic [SLOT_W-1:0] issue_idx,
	input  logic [TW-1:0]     rd_iv,
	input  logic [TW-1:0]     rd_lm,
	input  slot_flags_t       flags,
	input  logic [TW-1:0]     cur_time,
	output logic [SLOT_W-1:0] idx_s1,
	output pipe_stat_t        stat,
	output logic [SLOT_W-1:0] wb_idx,
	output logic [TW-1:0]     wb_iv,
	output logic [TW-1:0]     wb_lm,
	output logic [TW-1:0]     nxt_s3
);

	logic              v_s1, v_s2, v_s3;
	logic [SLOT_W-1:0] idx_s2;
	logic [TW-1:0]     iv_s2, due_s2;
	logic              act_s2, act_s3;

	logic [TW-1:0] lm;
	logic [TW:0]   sum1, sum2;
	logic [TW-1:0] due, due_next, nxt;
	logic          act, adv;

	// Stage 1: the read word is here; work out when the timer falls due.
	always_comb begin
		lm   = flags.lm_zero ? '0 : rd_lm;
		sum1 = {1'b0, lm} + {1'b0, rd_iv};
		due  = sum1[TW] ? '1 : sum1[TW-1:0];
		act  = flags.slot_valid && (rd_iv != '0);
	end

	// Stage 2: advance a due timer and find its next measurement time.
	always_comb begin
		adv      = cur_time >= due_s2;
		sum2     = {1'b0, due_s2} + {1'b0, iv_s2};
		due_next = sum2[TW] ? '1 : sum2[TW-1:0];
		nxt      = adv ? due_next : due_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		idx_s2 <= idx_s1;
		iv_s2  <= rd_iv;
		due_s2 <= due;
		act_s2 <= act;
		nxt_s3 <= nxt;
		act_s3 <= act_s2;
	end

	assign wb_idx      = idx_s2;
	assign wb_iv       = iv_s2;
	assign wb_lm       = due_s2;
	assign stat.busy   = v_s1 || v_s2 || v_s3;
	assign stat.wb_en  = v_s2 && act_s2 && adv;
	assign stat.upd_en = v_s3 && act_s3;

endmodule

// ----- hw/rtl/pesl_checker.sv -----
`include "periodic_event_step_limiter_top_macros.svh"

module pesl_checker import pesl_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result word stays put.
	`PESL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

	// Only a cancel sets found, and a cancel carries no step length.
	`PESL_ASSERT_SAME(a_found_no_step, m_axis_tvalid && m_axis_tdata[FIELD_TIME_W], m_axis_tdata[FIELD_TIME_W-1:0] == '0, "found set together with a step length")

	// One word is in work at a time.
	`PESL_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again right after acceptance")

	// No result appears in the cycle right after a word is accepted.
	`PESL_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared too early")

endmodule

bind periodic_event_step_limiter_top pesl_checker u_pesl_checker (.*);
